### src/cmsp_pkg.sv
`timescale 1ns / 1ps

package cmsp_pkg;

    // Parse phase codes
    localparam logic [2:0] PH_HEADER  = 3'd0;
    localparam logic [2:0] PH_TOKEN   = 3'd1;
    localparam logic [2:0] PH_OPTHEAD = 3'd2;
    localparam logic [2:0] PH_OPTEXT  = 3'd3;
    localparam logic [2:0] PH_VALUE   = 3'd4;
    localparam logic [2:0] PH_PAYLOAD = 3'd5;
    localparam logic [2:0] PH_SKIP    = 3'd6;

    // Result kinds
    localparam logic [2:0] KIND_INSIDE  = 3'd0;
    localparam logic [2:0] KIND_HEADER  = 3'd1;
    localparam logic [2:0] KIND_TOKEN   = 3'd2;
    localparam logic [2:0] KIND_OPTION  = 3'd3;
    localparam logic [2:0] KIND_VALUE   = 3'd4;
    localparam logic [2:0] KIND_MARKER  = 3'd5;
    localparam logic [2:0] KIND_PAYLOAD = 3'd6;

    // Status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_TRUNCATED = 2'd1;
    localparam logic [1:0] STATUS_BAD_VER   = 2'd2;

    // Protocol constants
    localparam logic [7:0]  MARKER_BYTE     = 8'hFF;
    localparam logic [3:0]  NIB_EXT_ONE     = 4'd13;
    localparam logic [3:0]  NIB_EXT_TWO     = 4'd14;
    localparam logic [16:0] EXT_ONE_BASE    = 17'd13;
    localparam logic [16:0] EXT_TWO_BASE    = 17'd269;
    localparam logic [3:0]  HEADER_LAST_IDX = 4'd3;
    localparam logic [1:0]  PROTO_VERSION   = 2'd1;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  data_byte;
        logic [1:0]  version;
        logic [1:0]  msg_type;
        logic [3:0]  token_length;
        logic [7:0]  code;
        logic [15:0] msg_id;
        logic [15:0] opt_number;
        logic [16:0] option_length;
        logic        message_end;
        logic [1:0]  status;
    } out_item_t;

    typedef struct packed {
        logic [2:0]  phase;
        logic [3:0]  field_counter;
        logic [23:0] header_bits;
        logic [15:0] previous_option;
        logic [16:0] delta_gather;
        logic [16:0] length_gather;
        logic [7:0]  pending_nibbles;
        logic [16:0] value_remaining;
        logic        bad_version;
    } state_t;

    localparam state_t STATE_RESET = '{
        phase:           PH_HEADER,
        field_counter:   4'd0,
        header_bits:     24'd0,
        previous_option: 16'd0,
        delta_gather:    17'd0,
        length_gather:   17'd0,
        pending_nibbles: 8'd0,
        value_remaining: 17'd0,
        bad_version:     1'b0
    };

endpackage

### src/cmsp_if.sv
`timescale 1ns / 1ps

// Byte channel into the parser
interface cmsp_in_if;
    logic                valid;
    logic                ready;
    cmsp_pkg::in_item_t  payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// Result channel out of the parser
interface cmsp_out_if;
    logic                valid;
    logic                ready;
    cmsp_pkg::out_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### src/cmsp_step.sv
`timescale 1ns / 1ps

// Per-byte parse step: next state and the one result for the byte
module cmsp_step (
    input  cmsp_pkg::state_t    state,
    input  cmsp_pkg::in_item_t  item,
    output cmsp_pkg::state_t    state_next,
    output cmsp_pkg::out_item_t res
);
    import cmsp_pkg::*;

    function automatic logic [1:0] ext_count(input logic [3:0] nib);
        logic [1:0] n;
        n = 2'd0;
        if (nib == NIB_EXT_ONE)
            n = 2'd1;
        else if (nib == NIB_EXT_TWO)
            n = 2'd2;
        return n;
    endfunction

    logic [7:0]  b;
    logic        last;
    logic        trunc;
    logic        do_finish;
    logic [16:0] fin_len;
    logic [15:0] num;
    state_t      nx;
    out_item_t   r;

    // option header nibbles and extension bookkeeping
    logic [1:0]  hd_ed, hd_el;
    logic [1:0]  px_ed, px_el;
    logic        sel_delta;
    logic [3:0]  ext_k;
    logic [1:0]  ext_n;
    logic [7:0]  ext_g;
    logic [16:0] ext_new;
    logic [4:0]  ext_idx_inc;
    logic [2:0]  ext_total;
    logic [3:0]  token_dec;
    logic [7:0]  b0;

    assign b    = item.in_byte;
    assign last = item.in_last;

    assign hd_ed = ext_count(b[7:4]);
    assign hd_el = ext_count(b[3:0]);
    assign px_ed = ext_count(state.pending_nibbles[7:4]);
    assign px_el = ext_count(state.pending_nibbles[3:0]);

    // extension byte: pick delta or length gatherer
    assign sel_delta   = state.field_counter < {2'b00, px_ed};
    assign ext_k       = sel_delta ? state.field_counter
                                   : state.field_counter - {2'b00, px_ed};
    assign ext_n       = sel_delta ? px_ed : px_el;
    assign ext_g       = sel_delta ? state.delta_gather[7:0] : state.length_gather[7:0];
    assign ext_idx_inc = {1'b0, state.field_counter} + 5'd1;
    assign ext_total   = {1'b0, px_ed} + {1'b0, px_el};
    assign token_dec   = state.field_counter - 4'd1;
    assign b0          = state.header_bits[23:16];

    always_comb
    begin
        if (ext_n == 2'd1)
            ext_new = EXT_ONE_BASE + {9'd0, b};
        else if (ext_k == 4'd0)
            ext_new = {9'd0, b};
        else
            ext_new = {1'b0, ext_g, b} + EXT_TWO_BASE;
    end

    always_comb
    begin
        nx        = state;
        r         = '0;
        trunc     = 1'b0;
        do_finish = 1'b0;
        num       = 16'd0;

        unique case (state.phase)
            PH_TOKEN:
            begin
                r.kind           = KIND_TOKEN;
                r.data_byte      = b;
                nx.field_counter = token_dec;
                if (token_dec == 4'd0)
                    nx.phase = PH_OPTHEAD;
                else
                    trunc = last;
            end
            PH_OPTHEAD:
            begin
                if (b == MARKER_BYTE)
                begin
                    r.kind   = KIND_MARKER;
                    nx.phase = PH_PAYLOAD;
                end
                else
                begin
                    nx.pending_nibbles = b;
                    nx.delta_gather    = {13'd0, b[7:4]};
                    nx.length_gather   = {13'd0, b[3:0]};
                    if ((hd_ed == 2'd0) && (hd_el == 2'd0))
                        do_finish = 1'b1;
                    else
                    begin
                        nx.field_counter = 4'd0;
                        nx.phase         = PH_OPTEXT;
                        trunc            = last;
                    end
                end
            end
            PH_OPTEXT:
            begin
                if (sel_delta)
                    nx.delta_gather = ext_new;
                else
                    nx.length_gather = ext_new;
                nx.field_counter = ext_idx_inc[3:0];
                if (ext_idx_inc >= {2'b00, ext_total})
                    do_finish = 1'b1;
                else
                    trunc = last;
            end
            PH_VALUE:
            begin
                r.kind             = KIND_VALUE;
                r.data_byte        = b;
                nx.value_remaining = state.value_remaining - 17'd1;
                if (nx.value_remaining == 17'd0)
                    nx.phase = PH_OPTHEAD;
                else
                    trunc = last;
            end
            PH_PAYLOAD:
            begin
                r.kind      = KIND_PAYLOAD;
                r.data_byte = b;
            end
            PH_SKIP:
            begin
                r.kind = KIND_INSIDE;
            end
            default:
            begin
                // header phase, and the unused code
                if (state.field_counter < HEADER_LAST_IDX)
                begin
                    nx.header_bits   = {state.header_bits[15:0], b};
                    nx.field_counter = state.field_counter + 4'd1;
                    trunc            = last;
                end
                else
                begin
                    r.kind         = KIND_HEADER;
                    r.version      = b0[7:6];
                    r.msg_type     = b0[5:4];
                    r.token_length = b0[3:0];
                    r.code         = state.header_bits[15:8];
                    r.msg_id       = {state.header_bits[7:0], b};
                    if (b0[7:6] != PROTO_VERSION)
                    begin
                        nx.bad_version = 1'b1;
                        nx.phase       = PH_SKIP;
                    end
                    else
                    begin
                        nx.field_counter = b0[3:0];
                        nx.phase         = (b0[3:0] != 4'd0) ? PH_TOKEN : PH_OPTHEAD;
                        trunc            = last && (b0[3:0] != 4'd0);
                    end
                end
            end
        endcase

        // option header complete: absolute number and value length
        fin_len = nx.length_gather;
        if (do_finish)
        begin
            num                = state.previous_option + nx.delta_gather[15:0];
            nx.previous_option = num;
            r.kind             = KIND_OPTION;
            r.opt_number       = num;
            r.option_length    = fin_len;
            nx.value_remaining = fin_len;
            nx.phase           = (fin_len != 17'd0) ? PH_VALUE : PH_OPTHEAD;
            trunc              = last && (fin_len != 17'd0);
        end

        r.message_end = last;
        priority if (nx.bad_version)
            r.status = STATUS_BAD_VER;
        else if (trunc)
            r.status = STATUS_TRUNCATED;
        else
            r.status = STATUS_OK;

        // end of message: back to a clean state
        if (last)
            nx = STATE_RESET;
    end

    assign state_next = nx;
    assign res        = r;

endmodule

### src/coap_message_stream_parser.sv
`timescale 1ns / 1ps

// Streaming CoAP message parser. One message byte enters per item on msg,
// with in_last on the final byte, and exactly one result item leaves on
// result for every byte, in order: header done (version, type, token length,
// code, message id), token byte, option done (absolute number modulo 65536
// and value length), option value byte, payload marker, payload byte, or
// "inside a field". Status flags a bad version (every later byte of that
// message then reads kind 0) or a message that ends inside the header,
// token, an option header or an option value. Throughput is one byte per
// clock while the result is drained; the parse state and the result register
// are both updated in the cycle a byte is taken, and msg.ready stays high
// whenever the result register is empty or is being drained. State returns
// to reset after every last byte.
module coap_message_stream_parser (
    input logic       clk,
    input logic       rst_n,
    cmsp_in_if.sink   msg,
    cmsp_out_if.source result
);
    import cmsp_pkg::*;

    state_t    state_reg;
    state_t    state_next;
    out_item_t res_reg;
    out_item_t res_next;
    logic      res_valid_reg;
    logic      accept;

    assign msg.ready = !res_valid_reg || result.ready;
    assign accept    = msg.valid && msg.ready;

    cmsp_step u_step (
        .state      (state_reg),
        .item       (msg.payload),
        .state_next (state_next),
        .res        (res_next)
    );

    // parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= STATE_RESET;
        else if (accept)
            state_reg <= state_next;
    end

    // result register valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (accept)
            res_valid_reg <= 1'b1;
        else if (result.ready)
            res_valid_reg <= 1'b0;
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (accept)
            res_reg <= res_next;
    end

    assign result.valid   = res_valid_reg;
    assign result.payload = res_reg;

endmodule
